@@ rtl/connection_stage_abort_tracker_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the connection stage abort tracker.
// Shared checks written against a clock and an active-low reset.
// ----------------------------------------------------------------------------
`ifndef CONNECTION_STAGE_ABORT_TRACKER_UNIT_DEFINES_SVH
`define CONNECTION_STAGE_ABORT_TRACKER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSTAT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSTAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/cstat_pkg.sv @@
// ----------------------------------------------------------------------------
// Connection stage abort tracker package
// Shared constants, codes and types for the tracker modules.
// ----------------------------------------------------------------------------
package cstat_pkg;

	localparam int FLOWS          = 1024;
	localparam int FLOW_BITS      = $clog2(FLOWS);
	localparam int COUNT_BITS     = 32;
	localparam int STAGES         = 4;
	localparam int STAGE_IDX_BITS = $clog2(STAGES);

	localparam int CMD_BITS   = 3;
	localparam int FLOW_ID_BITS = 10;
	localparam int SOCK_BITS  = 4;
	localparam int STAGE_BITS = 3;
	localparam int KIND_BITS  = 2;
	localparam int VALUE_BITS = 32;

	typedef logic [STAGE_BITS-1:0] stage_t;
	typedef logic [COUNT_BITS-1:0] count_t;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_SYN   = 3'd0,
		CMD_ACK   = 3'd1,
		CMD_PSH   = 3'd2,
		CMD_DATA  = 3'd3,
		CMD_CLOSE = 3'd4
	} command_t;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_NONE  = 2'd0,
		KIND_TOTAL = 2'd1,
		KIND_ABORT = 2'd2
	} kind_t;

	localparam logic [SOCK_BITS-1:0] SOCK_FIN_WAIT1 = 4'd4;
	localparam logic [SOCK_BITS-1:0] SOCK_FIN_WAIT2 = 4'd5;
	localparam logic [SOCK_BITS-1:0] SOCK_CLOSED    = 4'd7;

	localparam stage_t STAGE_NONE  = 3'd0;
	localparam stage_t STAGE_FIRST = 3'd1;
	localparam stage_t STAGE_LAST  = 3'd4;

	typedef struct packed {
		logic [CMD_BITS-1:0]     command;
		logic [FLOW_ID_BITS-1:0] flow_id;
		logic [SOCK_BITS-1:0]    socket_state;
	} event_t;

	typedef struct packed {
		stage_t                stage_after;
		kind_t                 counted_kind;
		stage_t                counted_stage;
		logic [VALUE_BITS-1:0] count_value;
	} result_t;

	typedef struct packed {
		logic                 en;
		logic [FLOW_BITS-1:0] addr;
		stage_t               data;
	} table_wr_t;

endpackage

@@ rtl/cstat_event_if.sv @@
// ----------------------------------------------------------------------------
// Event channel
// Valid/ready channel that carries one tracker event per transaction.
// ----------------------------------------------------------------------------
interface cstat_event_if;

	logic                              valid;
	logic                              ready;
	logic [cstat_pkg::CMD_BITS-1:0]    command;
	logic [cstat_pkg::FLOW_ID_BITS-1:0] flow_id;
	logic [cstat_pkg::SOCK_BITS-1:0]   socket_state;

	modport source (output valid, output command, output flow_id, output socket_state,
		input ready);
	modport sink (input valid, input command, input flow_id, input socket_state,
		output ready);

endinterface

@@ rtl/cstat_result_if.sv @@
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one tracker result per transaction.
// ----------------------------------------------------------------------------
interface cstat_result_if;

	logic                               valid;
	logic                               ready;
	logic [cstat_pkg::STAGE_BITS-1:0]   stage_after;
	logic [cstat_pkg::KIND_BITS-1:0]    counted_kind;
	logic [cstat_pkg::STAGE_BITS-1:0]   counted_stage;
	logic [cstat_pkg::VALUE_BITS-1:0]   count_value;

	modport source (output valid, output stage_after, output counted_kind,
		output counted_stage, output count_value, input ready);
	modport sink (input valid, input stage_after, input counted_kind,
		input counted_stage, input count_value, output ready);

endinterface

@@ rtl/cstat_flow_table.sv @@
// ----------------------------------------------------------------------------
// Flow stage table
// One-read one-write memory of flow stages with a clearing pass after reset.
// ----------------------------------------------------------------------------
module cstat_flow_table (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            rd_en,
	input  logic [cstat_pkg::FLOW_BITS-1:0] rd_addr,
	output cstat_pkg::stage_t               rd_data,
	input  cstat_pkg::table_wr_t            wr,
	output logic                            busy
);

	cstat_pkg::stage_t               mem_q [cstat_pkg::FLOWS];
	cstat_pkg::stage_t               rd_data_q;
	logic [cstat_pkg::FLOW_BITS-1:0] clear_idx_q;
	logic                            busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b1;
			clear_idx_q <= '0;
		end else if (busy_q) begin
			clear_idx_q <= clear_idx_q + 1'b1;
			if (clear_idx_q == cstat_pkg::FLOW_BITS'(cstat_pkg::FLOWS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem_q[clear_idx_q] <= cstat_pkg::STAGE_NONE;
		end else if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = busy_q;

endmodule

@@ rtl/cstat_update.sv @@
// ----------------------------------------------------------------------------
// Stage update and counters
// Works out the new flow stage and bumps the saturating stage counters.
// ----------------------------------------------------------------------------
module cstat_update (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cstat_pkg::event_t    ev,
	input  cstat_pkg::stage_t    cur_stage,
	input  logic                 commit,
	output cstat_pkg::result_t   result,
	output cstat_pkg::table_wr_t wr
);

	cstat_pkg::count_t                    totals_q [cstat_pkg::STAGES];
	cstat_pkg::count_t                    aborts_q [cstat_pkg::STAGES];
	logic                                 in_range;
	logic                                 abort_state;
	cstat_pkg::stage_t                    next_stage;
	cstat_pkg::kind_t                     kind;
	cstat_pkg::stage_t                    cnt_stage;
	logic [cstat_pkg::STAGE_IDX_BITS-1:0] idx;
	cstat_pkg::count_t                    sel_count;
	cstat_pkg::count_t                    bumped;

	assign in_range    = (32'(ev.flow_id) < cstat_pkg::FLOWS);
	assign abort_state = (ev.socket_state == cstat_pkg::SOCK_CLOSED) ||
		(ev.socket_state == cstat_pkg::SOCK_FIN_WAIT1) ||
		(ev.socket_state == cstat_pkg::SOCK_FIN_WAIT2);

	always_comb begin
		next_stage = cur_stage;
		kind       = cstat_pkg::KIND_NONE;
		cnt_stage  = cstat_pkg::STAGE_NONE;
		if (!in_range) begin
			next_stage = cstat_pkg::STAGE_NONE;
		end else begin
			case (ev.command)
				cstat_pkg::CMD_SYN: begin
					next_stage = cstat_pkg::STAGE_FIRST;
					kind       = cstat_pkg::KIND_TOTAL;
					cnt_stage  = cstat_pkg::STAGE_FIRST;
				end
				cstat_pkg::CMD_ACK, cstat_pkg::CMD_PSH, cstat_pkg::CMD_DATA: begin
					if (cur_stage == ev.command) begin
						next_stage = cur_stage + 1'b1;
						kind       = cstat_pkg::KIND_TOTAL;
						cnt_stage  = cur_stage + 1'b1;
					end
				end
				cstat_pkg::CMD_CLOSE: begin
					if (cur_stage inside {[cstat_pkg::STAGE_FIRST:cstat_pkg::STAGE_LAST]}
						&& abort_state) begin
						next_stage = cstat_pkg::STAGE_NONE;
						kind       = cstat_pkg::KIND_ABORT;
						cnt_stage  = cur_stage;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign idx       = cstat_pkg::STAGE_IDX_BITS'(cnt_stage - 1'b1);
	assign sel_count = (kind == cstat_pkg::KIND_ABORT) ? aborts_q[idx] : totals_q[idx];
	assign bumped    = (sel_count == '1) ? sel_count : sel_count + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cstat_pkg::STAGES; i++) begin
				totals_q[i] <= '0;
				aborts_q[i] <= '0;
			end
		end else if (commit) begin
			if (kind == cstat_pkg::KIND_TOTAL) begin
				totals_q[idx] <= bumped;
			end else if (kind == cstat_pkg::KIND_ABORT) begin
				aborts_q[idx] <= bumped;
			end
		end
	end

	always_comb begin
		result.stage_after   = next_stage;
		result.counted_kind  = kind;
		result.counted_stage = cnt_stage;
		result.count_value   = (kind == cstat_pkg::KIND_NONE) ? '0 :
			cstat_pkg::VALUE_BITS'(bumped);
	end

	assign wr.en   = commit && in_range;
	assign wr.addr = ev.flow_id[cstat_pkg::FLOW_BITS-1:0];
	assign wr.data = next_stage;

endmodule

@@ rtl/connection_stage_abort_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// Connection stage abort tracker
// Tracks the handshake stage of each flow and counts stage entries and aborts.
// ----------------------------------------------------------------------------
// The events channel takes one transaction per event: a command, a flow number
// and the socket state. The results channel gives exactly one transaction per
// event, in order: the flow's stage after the event and, where a counter moved,
// which counter and its new saturated value.
// An accepted event is registered in the working stage and moves on to the
// output register once that is free. One event is taken every cycle while the
// results receiver does not stall; the limit is the single read and single
// write port of the flow stage table. Reset clears the counters and starts a
// clearing pass over the whole flow table; events are refused until it completes.
// When the results receiver stalls, the output register holds its result and
// the event in the working stage waits behind it; events are refused only
// once both are full.
// ----------------------------------------------------------------------------
`include "connection_stage_abort_tracker_unit_defines.svh"

module connection_stage_abort_tracker_unit (
	input logic            clk,
	input logic            arst_n,
	cstat_event_if.sink    events,
	cstat_result_if.source results
);

	logic                            accept;
	logic                            advance;
	logic                            commit;
	logic                            table_busy;
	cstat_pkg::stage_t               rd_data;
	cstat_pkg::stage_t               cur_stage;
	cstat_pkg::result_t              result;
	cstat_pkg::table_wr_t            wr;
	cstat_pkg::event_t               ev_s1;
	logic                            valid_s1;
	cstat_pkg::result_t              res_s2;
	logic                            valid_s2;
	logic                            byp_valid_q;
	logic [cstat_pkg::FLOW_BITS-1:0] byp_addr_q;
	cstat_pkg::stage_t               byp_data_q;

	assign advance      = !valid_s2 || results.ready;
	assign commit       = valid_s1 && advance;
	assign events.ready = !table_busy && (!valid_s1 || advance);
	assign accept       = events.valid && events.ready;

	cstat_flow_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (events.flow_id[cstat_pkg::FLOW_BITS-1:0]),
		.rd_data (rd_data),
		.wr      (wr),
		.busy    (table_busy)
	);

	// The write made at the edge that loaded this stage is not seen by the read.
	assign cur_stage = (byp_valid_q && byp_addr_q == ev_s1.flow_id[cstat_pkg::FLOW_BITS-1:0])
		? byp_data_q : rd_data;

	cstat_update u_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev        (ev_s1),
		.cur_stage (cur_stage),
		.commit    (commit),
		.result    (result),
		.wr        (wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			byp_valid_q <= 1'b0;
		end else begin
			if (!valid_s1 || advance) begin
				valid_s1 <= accept;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (wr.en) begin
				byp_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ev_s1.command      <= events.command;
			ev_s1.flow_id      <= events.flow_id;
			ev_s1.socket_state <= events.socket_state;
		end
		if (commit) begin
			res_s2 <= result;
		end
		if (wr.en) begin
			byp_addr_q <= wr.addr;
			byp_data_q <= wr.data;
		end
	end

	assign results.valid         = valid_s2;
	assign results.stage_after   = res_s2.stage_after;
	assign results.counted_kind  = res_s2.counted_kind;
	assign results.counted_stage = res_s2.counted_stage;
	assign results.count_value   = res_s2.count_value;

	`CSTAT_ASSERT_SAME(a_none_is_empty, clk, arst_n,
		valid_s2 && res_s2.counted_kind == cstat_pkg::KIND_NONE,
		res_s2.counted_stage == cstat_pkg::STAGE_NONE && res_s2.count_value == '0,
		"Result with nothing counted carries a stage or value.")
	`CSTAT_ASSERT_SAME(a_abort_untracks, clk, arst_n,
		valid_s2 && res_s2.counted_kind == cstat_pkg::KIND_ABORT,
		res_s2.stage_after == cstat_pkg::STAGE_NONE,
		"Abort result leaves the flow tracked.")
	`CSTAT_ASSERT_SAME(a_total_matches_stage, clk, arst_n,
		valid_s2 && res_s2.counted_kind == cstat_pkg::KIND_TOTAL,
		res_s2.stage_after == res_s2.counted_stage,
		"Stage total counted for a stage other than the new one.")
	`CSTAT_ASSERT_NEXT(a_commit_reaches_output, clk, arst_n,
		commit, valid_s2,
		"Committed transaction did not reach the output register.")
	`CSTAT_ASSERT_SAME(a_no_accept_while_clearing, clk, arst_n,
		table_busy, !valid_s1 && !valid_s2,
		"Transaction in flight during the flow table clearing pass.")

endmodule

@@ tb/tb_connection_stage_abort_tracker_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Connection stage abort tracker testbench
// Drives tracker events through the event channel and checks every result:
// typed table rows against their own entry, the rest against a predictor of
// the flow table and stage counters. A short table of directed events comes
// first. Random events follow, mostly well-formed connection sequences on a
// small pool of flows, under three settings of sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_connection_stage_abort_tracker_unit;

	import cstat_pkg::*;

	localparam logic [CMD_BITS-1:0] CMD_SPARE5 = 3'd5;
	localparam logic [CMD_BITS-1:0] CMD_SPARE6 = 3'd6;
	localparam logic [CMD_BITS-1:0] CMD_SPARE7 = 3'd7;

	localparam logic [SOCK_BITS-1:0] SOCK_NONE       = 4'd0;
	localparam logic [SOCK_BITS-1:0] SOCK_CLOSE_WAIT = 4'd8;
	localparam logic [SOCK_BITS-1:0] SOCK_TOP        = 4'hF;

	localparam logic [FLOW_ID_BITS-1:0] FLOW_LOW  = '0;
	localparam logic [FLOW_ID_BITS-1:0] FLOW_MID  = 10'd512;
	localparam logic [FLOW_ID_BITS-1:0] FLOW_HIGH = '1;

	localparam int POOL_SIZE        = 24;
	localparam int RANDOM_PER_PHASE = 442;
	localparam int PHASES           = 3;
	localparam int SEND_IDLE [PHASES] = '{27, 45, 0};
	localparam int RECV_IDLE [PHASES] = '{45, 27, 0};

	typedef struct packed {
		logic [CMD_BITS-1:0]     command;
		logic [FLOW_ID_BITS-1:0] flow_id;
		logic [SOCK_BITS-1:0]    socket_state;
		logic                    typed;
		result_t                 want;
	} plan_row_t;

	localparam int PLAN_ROWS = 24;
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		'{CMD_ACK,    FLOW_LOW,  SOCK_NONE,       1'b1, '{STAGE_NONE, KIND_NONE, STAGE_NONE, 32'd0}},
		'{CMD_CLOSE,  FLOW_LOW,  SOCK_CLOSED,     1'b1, '{STAGE_NONE, KIND_NONE, STAGE_NONE, 32'd0}},
		'{CMD_SYN,    FLOW_LOW,  SOCK_NONE,       1'b1, '{3'd1, KIND_TOTAL, 3'd1, 32'd1}},
		'{CMD_PSH,    FLOW_LOW,  SOCK_NONE,       1'b1, '{3'd1, KIND_NONE, STAGE_NONE, 32'd0}},
		'{CMD_ACK,    FLOW_LOW,  SOCK_NONE,       1'b1, '{3'd2, KIND_TOTAL, 3'd2, 32'd1}},
		'{CMD_ACK,    FLOW_LOW,  SOCK_NONE,       1'b1, '{3'd2, KIND_NONE, STAGE_NONE, 32'd0}},
		'{CMD_PSH,    FLOW_LOW,  SOCK_NONE,       1'b1, '{3'd3, KIND_TOTAL, 3'd3, 32'd1}},
		'{CMD_DATA,   FLOW_LOW,  SOCK_NONE,       1'b1, '{3'd4, KIND_TOTAL, 3'd4, 32'd1}},
		'{CMD_SYN,    FLOW_LOW,  SOCK_TOP,        1'b1, '{3'd1, KIND_TOTAL, 3'd1, 32'd2}},
		'{CMD_ACK,    FLOW_LOW,  SOCK_NONE,       1'b1, '{3'd2, KIND_TOTAL, 3'd2, 32'd2}},
		'{CMD_CLOSE,  FLOW_LOW,  SOCK_CLOSE_WAIT, 1'b1, '{3'd2, KIND_NONE, STAGE_NONE, 32'd0}},
		'{CMD_CLOSE,  FLOW_LOW,  SOCK_FIN_WAIT1,  1'b1, '{STAGE_NONE, KIND_ABORT, 3'd2, 32'd1}},
		'{CMD_SYN,    FLOW_HIGH, SOCK_NONE,       1'b1, '{3'd1, KIND_TOTAL, 3'd1, 32'd3}},
		'{CMD_SPARE5, FLOW_HIGH, SOCK_TOP,        1'b1, '{3'd1, KIND_NONE, STAGE_NONE, 32'd0}},
		'{CMD_SPARE6, FLOW_HIGH, SOCK_CLOSED,     1'b1, '{3'd1, KIND_NONE, STAGE_NONE, 32'd0}},
		'{CMD_SPARE7, FLOW_HIGH, SOCK_TOP,        1'b1, '{3'd1, KIND_NONE, STAGE_NONE, 32'd0}},
		'{CMD_CLOSE,  FLOW_HIGH, SOCK_TOP,        1'b1, '{3'd1, KIND_NONE, STAGE_NONE, 32'd0}},
		'{CMD_CLOSE,  FLOW_HIGH, SOCK_FIN_WAIT2,  1'b1, '{STAGE_NONE, KIND_ABORT, 3'd1, 32'd1}},
		'{CMD_SYN,    FLOW_MID,  SOCK_NONE,       1'b0, '0},
		'{CMD_ACK,    FLOW_MID,  SOCK_NONE,       1'b0, '0},
		'{CMD_PSH,    FLOW_MID,  SOCK_NONE,       1'b0, '0},
		'{CMD_DATA,   FLOW_MID,  SOCK_NONE,       1'b0, '0},
		'{CMD_CLOSE,  FLOW_MID,  SOCK_CLOSED,     1'b0, '0},
		'{CMD_CLOSE,  FLOW_MID,  SOCK_CLOSED,     1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cstat_event_if  ev_ch ();
	cstat_result_if res_ch ();

	connection_stage_abort_tracker_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.events  (ev_ch),
		.results (res_ch)
	);

	stage_t  flow_stage_model [FLOWS];
	count_t  entry_counts [STAGES];
	count_t  abort_counts [STAGES];
	result_t expected_results [$];
	logic [FLOW_ID_BITS-1:0] flow_pool [POOL_SIZE];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatch_count = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic count_t saturating_inc(input count_t c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	function automatic result_t track_event(input logic [CMD_BITS-1:0] cmd,
			input logic [FLOW_ID_BITS-1:0] flow, input logic [SOCK_BITS-1:0] sock);
		result_t r;
		stage_t  cur;
		int      idx;
		r = '0;
		if (int'(flow) >= FLOWS)
			return r;
		cur = flow_stage_model[flow];
		case (cmd)
			CMD_SYN: begin
				cur = STAGE_FIRST;
				idx = int'(cur) - 1;
				entry_counts[idx] = saturating_inc(entry_counts[idx]);
				r.counted_kind  = KIND_TOTAL;
				r.counted_stage = cur;
				r.count_value   = VALUE_BITS'(entry_counts[idx]);
			end
			CMD_ACK, CMD_PSH, CMD_DATA: begin
				// Each of these moves a flow on by one, from the stage equal to its code.
				if (cur == stage_t'(cmd)) begin
					cur = cur + 1'b1;
					idx = int'(cur) - 1;
					entry_counts[idx] = saturating_inc(entry_counts[idx]);
					r.counted_kind  = KIND_TOTAL;
					r.counted_stage = cur;
					r.count_value   = VALUE_BITS'(entry_counts[idx]);
				end
			end
			CMD_CLOSE: begin
				if (cur >= STAGE_FIRST && cur <= STAGE_LAST &&
						(sock == SOCK_CLOSED || sock == SOCK_FIN_WAIT1 ||
						sock == SOCK_FIN_WAIT2)) begin
					idx = int'(cur) - 1;
					abort_counts[idx] = saturating_inc(abort_counts[idx]);
					r.counted_kind  = KIND_ABORT;
					r.counted_stage = cur;
					r.count_value   = VALUE_BITS'(abort_counts[idx]);
					cur = STAGE_NONE;
				end
			end
			default: begin
			end
		endcase
		flow_stage_model[flow] = cur;
		r.stage_after = cur;
		return r;
	endfunction

	task automatic push_event(input logic [CMD_BITS-1:0] cmd,
			input logic [FLOW_ID_BITS-1:0] flow, input logic [SOCK_BITS-1:0] sock,
			input logic typed, input result_t want);
		result_t predicted;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			ev_ch.valid = 1'b0;
			@(negedge clk);
		end
		ev_ch.valid        = 1'b1;
		ev_ch.command      = cmd;
		ev_ch.flow_id      = flow;
		ev_ch.socket_state = sock;
		do
			@(posedge clk);
		while (ev_ch.ready !== 1'b1);
		predicted = track_event(cmd, flow, sock);
		expected_results.push_back(typed ? want : predicted);
	endtask

	task automatic drain_results();
		@(negedge clk);
		ev_ch.valid = 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [SOCK_BITS-1:0] abort_sock();
		case ($urandom_range(0, 2))
			0: return SOCK_CLOSED;
			1: return SOCK_FIN_WAIT1;
			default: return SOCK_FIN_WAIT2;
		endcase
	endfunction

	task automatic push_random_event();
		logic [CMD_BITS-1:0]     cmd;
		logic [FLOW_ID_BITS-1:0] flow;
		logic [SOCK_BITS-1:0]    sock;
		stage_t                  cur;
		int                      pick;
		if ($urandom_range(0, 99) < 85)
			flow = flow_pool[$urandom_range(0, POOL_SIZE - 1)];
		else
			flow = FLOW_ID_BITS'($urandom_range(0, FLOWS - 1));
		sock = SOCK_BITS'($urandom_range(0, 15));
		cur  = flow_stage_model[flow];
		pick = $urandom_range(0, 99);
		if (pick < 62) begin
			// Take the flow one step further along a normal connection.
			if (cur == STAGE_NONE) begin
				cmd = CMD_SYN;
			end else if (cur == STAGE_LAST) begin
				cmd  = CMD_CLOSE;
				sock = abort_sock();
			end else begin
				cmd = CMD_BITS'(cur);
			end
		end else if (pick < 78) begin
			cmd = CMD_CLOSE;
			if ($urandom_range(0, 99) < 70)
				sock = abort_sock();
		end else if (pick < 88) begin
			cmd = CMD_SYN;
		end else begin
			cmd = CMD_BITS'($urandom_range(0, 7));
		end
		push_event(cmd, flow, sock, 1'b0, '0);
	endtask

	function automatic void report_mismatch(input result_t want);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$write("%0t: result mismatch: expected stage %0d kind %0d counted %0d value %0d,",
				$time, want.stage_after, want.counted_kind,
				want.counted_stage, want.count_value);
			$display(" got stage %0d kind %0d counted %0d value %0d",
				res_ch.stage_after, res_ch.counted_kind,
				res_ch.counted_stage, res_ch.count_value);
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: result transaction with none expected", $time);
			end else begin
				want = expected_results.pop_front();
				if (res_ch.stage_after !== want.stage_after ||
						res_ch.counted_kind !== want.counted_kind ||
						res_ch.counted_stage !== want.counted_stage ||
						res_ch.count_value !== want.count_value)
					report_mismatch(want);
			end
		end
	end

	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		ev_ch.valid        = 1'b0;
		ev_ch.command      = '0;
		ev_ch.flow_id      = '0;
		ev_ch.socket_state = '0;
		for (int f = 0; f < FLOWS; f++)
			flow_stage_model[f] = STAGE_NONE;
		for (int s = 0; s < STAGES; s++) begin
			entry_counts[s] = '0;
			abort_counts[s] = '0;
		end
		flow_pool[0] = FLOW_LOW;
		flow_pool[1] = FLOW_HIGH;
		for (int p = 2; p < POOL_SIZE; p++)
			flow_pool[p] = FLOW_ID_BITS'($urandom_range(0, FLOWS - 1));

		send_idle_pct = SEND_IDLE[0];
		recv_idle_pct = RECV_IDLE[0];
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < PLAN_ROWS; i++)
			push_event(PLAN[i].command, PLAN[i].flow_id, PLAN[i].socket_state,
				PLAN[i].typed, PLAN[i].want);

		for (int ph = 0; ph < PHASES; ph++) begin
			send_idle_pct = SEND_IDLE[ph];
			recv_idle_pct = RECV_IDLE[ph];
			for (int n = 0; n < RANDOM_PER_PHASE; n++)
				push_random_event();
			// The sender holds off here until every outstanding result has come back.
			drain_results();
		end

		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
